/* rtl/ccfp_pkg.sv */
package ccfp_pkg;

  localparam int FRAME_LEN = 8;
  localparam int FILL_W = $clog2(FRAME_LEN);
  localparam int CRC_START = 2;
  localparam int CRC_SPAN = 5;
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam int RESP_LEN = 4;
  localparam int RESP_IDX_W = $clog2(RESP_LEN);

  typedef enum logic [1:0] {
    RESP_OKAY        = 2'd0,
    RESP_BAD_COMMAND = 2'd1,
    RESP_BAD_STATE   = 2'd2
  } resp_code_t;

  typedef enum logic [1:0] {
    REG_COMMAND_MAGIC  = 2'd0,
    REG_RESPONSE_MAGIC = 2'd1,
    REG_BEGIN_CODE     = 2'd2,
    REG_END_CODE       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic       good;
    logic [7:0] cmd;
  } frame_stat_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* rtl/ccfp_window.sv */
module ccfp_window
  import ccfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        rx_data,
  input  logic              take,
  input  logic [15:0]       command_magic,
  output frame_stat_t       stat
);

  logic [7:0]        win [FRAME_LEN];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              complete;
  logic              magic_ok;
  logic [7:0]        crc;

  assign complete = (fill == FILL_W'(FRAME_LEN - 1));
  assign magic_ok = (win[0] == command_magic[15:8]) && (win[1] == command_magic[7:0]);

  always_comb begin
    crc = 8'h00;
    for (int k = 0; k < CRC_SPAN; k++) begin
      crc = crc8_byte(crc, win[FILL_W'(CRC_START + k)]);
    end
  end

  assign stat.good = complete && magic_ok && (crc == rx_data);
  assign stat.cmd  = win[CRC_START];

  always_comb begin
    priority if (!complete) begin
      fill_next = fill + 1'b1;
    end else if (magic_ok) begin
      fill_next = '0;
    end else begin
      fill_next = FILL_W'(FRAME_LEN - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (take) begin
      fill <= fill_next;
    end
  end

  // A full window whose sync bytes do not match slides down by one word.
  always_ff @(posedge clk) begin
    if (take) begin
      if (!complete) begin
        win[fill] <= rx_data;
      end else if (!magic_ok) begin
        for (int k = 0; k < FRAME_LEN - 2; k++) begin
          win[k] <= win[k + 1];
        end
        win[FRAME_LEN - 2] <= rx_data;
      end
    end
  end

endmodule

/* rtl/crc8_command_frame_parser_top.sv */
// Command frame parser with CRC-8 check.
// The rx channel carries one received byte per word; the tx channel carries
// the four words of a response frame, with last_byte high on the CRC word.
// Each accepted byte enters an input register and is handled from there, so
// a response word is first offered from the response registers after the
// byte that completes a good frame has left the input register. One rx word
// can be taken every cycle while rx_stall is low; a response occupies
// the tx channel for four words.
// The input register is held, and rx_stall raised, only while it holds the
// final byte of a good frame and an earlier response is still being sent;
// other bytes pass on while tx_stall holds a response.
// Configuration lives on the APB port: command magic at 0x0, response magic
// at 0x4, begin code at 0x8 and end code at 0xC. It should be written only
// while the block is idle.
// A synchronous reset clears the window fill, the tracing flag, the
// pending response and the registers (end code resets to one).
module crc8_command_frame_parser_top
  import ccfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        tx_valid,
  input  logic        tx_stall,
  output logic [7:0]  tx_byte,
  output logic        last_byte,
  output logic [1:0]  response_code,
  output logic        tracing_now
);

  logic [15:0]           command_magic;
  logic [15:0]           response_magic;
  logic [7:0]            begin_code;
  logic [7:0]            end_code;
  reg_idx_t              reg_idx;

  logic                  in_full;
  logic [7:0]            in_data;
  logic                  advance;
  frame_stat_t           stat;

  logic                  tracing;
  logic                  tracing_next;
  resp_code_t            code_next;

  logic                  resp_busy;
  logic [RESP_IDX_W-1:0] resp_idx;
  logic [15:0]           resp_magic;
  resp_code_t            resp_code;
  logic                  resp_tracing;
  logic                  tx_take;
  logic                  resp_done;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      command_magic  <= '0;
      response_magic <= '0;
      begin_code     <= 8'h00;
      end_code       <= 8'h01;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_COMMAND_MAGIC:  command_magic  <= pwdata[15:0];
        REG_RESPONSE_MAGIC: response_magic <= pwdata[15:0];
        REG_BEGIN_CODE:     begin_code     <= pwdata[7:0];
        REG_END_CODE:       end_code       <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COMMAND_MAGIC:  prdata = {16'h0000, command_magic};
      REG_RESPONSE_MAGIC: prdata = {16'h0000, response_magic};
      REG_BEGIN_CODE:     prdata = {24'h000000, begin_code};
      REG_END_CODE:       prdata = {24'h000000, end_code};
    endcase
  end

  // The response buffer is free this cycle unless a response is still pending
  // and its last word is not leaving now.
  assign tx_take   = tx_valid && !tx_stall;
  assign resp_done = tx_take && (resp_idx == RESP_IDX_W'(RESP_LEN - 1));
  assign advance   = in_full && (!stat.good || !resp_busy || resp_done);
  assign rx_stall  = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx_valid && !rx_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      in_data <= rx_byte;
    end
  end

  ccfp_window u_window (
    .clk           (clk),
    .rst           (rst),
    .rx_data       (in_data),
    .take          (advance),
    .command_magic (command_magic),
    .stat          (stat)
  );

  always_comb begin
    tracing_next = tracing;
    priority if (stat.cmd == begin_code) begin
      code_next    = tracing ? RESP_BAD_STATE : RESP_OKAY;
      tracing_next = 1'b1;
    end else if (stat.cmd == end_code) begin
      code_next    = tracing ? RESP_OKAY : RESP_BAD_STATE;
      tracing_next = 1'b0;
    end else begin
      code_next    = RESP_BAD_COMMAND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracing   <= 1'b0;
      resp_busy <= 1'b0;
      resp_idx  <= '0;
    end else if (advance && stat.good) begin
      tracing   <= tracing_next;
      resp_busy <= 1'b1;
      resp_idx  <= '0;
    end else if (tx_take) begin
      resp_busy <= !resp_done;
      resp_idx  <= resp_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stat.good) begin
      resp_magic   <= response_magic;
      resp_code    <= code_next;
      resp_tracing <= tracing_next;
    end
  end

  assign tx_valid      = resp_busy;
  assign response_code = resp_code;
  assign tracing_now   = resp_tracing;
  assign last_byte     = (resp_idx == RESP_IDX_W'(RESP_LEN - 1));

  always_comb begin
    unique case (resp_idx)
      2'd0:    tx_byte = resp_magic[15:8];
      2'd1:    tx_byte = resp_magic[7:0];
      2'd2:    tx_byte = {6'b000000, resp_code};
      default: tx_byte = crc8_byte(8'h00, {6'b000000, resp_code});
    endcase
  end

  a_last_word_ends: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && !tx_stall && last_byte) |=> (resp_idx == '0))
    else $error("response continued past its last word");

  a_code_legal: assert property (@(posedge clk) disable iff (rst)
    tx_valid |-> (response_code == RESP_OKAY || response_code == RESP_BAD_COMMAND ||
                  response_code == RESP_BAD_STATE))
    else $error("illegal response code");

  a_crc_word: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && last_byte) |-> (tx_byte == crc8_byte(8'h00, {6'b000000, response_code})))
    else $error("response CRC word does not match code");

  a_tracing_follows: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && response_code == RESP_OKAY && resp_idx == '0) |-> (tracing == tracing_now))
    else $error("tracing flag differs from reported state");

endmodule
